/* src/i2cm_pkg.sv */
// Shared types and codes for the I2C master transaction controller.
// Depends on nothing; every other file of the block imports it.
package i2cm_pkg;

	// Host actions carried on the input word.
	localparam logic [2:0] ACT_BEGIN_WR = 3'd0;
	localparam logic [2:0] ACT_QUEUE    = 3'd1;
	localparam logic [2:0] ACT_START_WR = 3'd2;
	localparam logic [2:0] ACT_START_RD = 3'd3;
	localparam logic [2:0] ACT_BUS_EVT  = 3'd4;
	localparam logic [2:0] ACT_POP      = 3'd5;

	// Two-wire engine status codes with the low three bits cleared.
	localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RESTART     = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST    = 8'h38;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	// Commands to the byte engine.
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_SEND    = 3'd2;
	localparam logic [2:0] CMD_ACK     = 3'd3;
	localparam logic [2:0] CMD_NACK    = 3'd4;
	localparam logic [2:0] CMD_STOP    = 3'd5;
	localparam logic [2:0] CMD_RELEASE = 3'd6;

	// Completion codes.
	localparam logic [1:0] FAULT_NONE      = 2'd0;
	localparam logic [1:0] FAULT_ADDR_NACK = 2'd1;
	localparam logic [1:0] FAULT_DATA_NACK = 2'd2;
	localparam logic [1:0] FAULT_OTHER     = 2'd3;

	// Operation class that the front end assigns to each word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_BEGIN_WR,
		OP_QUEUE,
		OP_START_WR,
		OP_START_RD,
		OP_POP,
		OP_EV_ADDR,
		OP_EV_TX_ACK,
		OP_EV_ADDR_NACK_W,
		OP_EV_DATA_NACK,
		OP_EV_ARB_LOST,
		OP_EV_RX_ADDR_ACK,
		OP_EV_RX_DATA_ACK,
		OP_EV_RX_DATA_NACK,
		OP_EV_ADDR_NACK_R,
		OP_EV_BUS_ERR
	} op_t;

	// Classified word held in the queue between front and back.
	typedef struct packed {
		op_t        op;
		logic [6:0] addr;
		logic [7:0] data;
		logic [7:0] count;
	} item_t;

endpackage

/* src/i2cm_front.sv */
// Front end: accepts input words and classifies them into queue items.
// Depends on i2cm_pkg.
module i2cm_front
	import i2cm_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [6:0] target_address,
	input  logic [7:0] data_byte,
	input  logic [7:0] byte_count,
	input  logic [7:0] bus_status,
	input  logic       q_full,
	output logic       push,
	output item_t      item
);

	localparam logic [7:0] DepthByte = 8'(BUFFER_DEPTH);

	logic [7:0] status_m;

	// Take a word whenever the queue has room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign status_m = {bus_status[7:3], 3'b000};

	// Decode the action and, for bus events, the engine status.
	always_comb begin
		item.addr  = target_address;
		item.data  = data_byte;
		item.count = (byte_count > DepthByte) ? DepthByte : byte_count;
		item.op    = OP_NONE;
		unique case (action)
			ACT_BEGIN_WR: item.op = OP_BEGIN_WR;
			ACT_QUEUE:    item.op = OP_QUEUE;
			ACT_START_WR: item.op = OP_START_WR;
			ACT_START_RD: item.op = OP_START_RD;
			ACT_POP:      item.op = OP_POP;
			ACT_BUS_EVT: begin
				unique case (status_m) inside
					ST_START, ST_RESTART:        item.op = OP_EV_ADDR;
					ST_SLA_W_ACK, ST_DATA_W_ACK: item.op = OP_EV_TX_ACK;
					ST_SLA_W_NACK:               item.op = OP_EV_ADDR_NACK_W;
					ST_DATA_W_NACK:              item.op = OP_EV_DATA_NACK;
					ST_ARB_LOST:                 item.op = OP_EV_ARB_LOST;
					ST_SLA_R_ACK:                item.op = OP_EV_RX_ADDR_ACK;
					ST_DATA_R_ACK:               item.op = OP_EV_RX_DATA_ACK;
					ST_DATA_R_NACK:              item.op = OP_EV_RX_DATA_NACK;
					ST_SLA_R_NACK:               item.op = OP_EV_ADDR_NACK_R;
					ST_BUS_ERROR:                item.op = OP_EV_BUS_ERR;
					default:                     item.op = OP_NONE;
				endcase
			end
			default: item.op = OP_NONE;
		endcase
	end

endmodule

/* src/i2cm_queue.sv */
// Two-entry queue of classified items between the front and back ends.
// Depends on i2cm_pkg.
module i2cm_queue
	import i2cm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* src/i2cm_back.sv */
// Back end: transaction state, send and receive buffers, and the output register.
// Depends on i2cm_pkg.
module i2cm_back
	import i2cm_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bus_command,
	output logic [7:0] bus_byte,
	output logic [7:0] host_byte,
	output logic       accepted,
	output logic       done_res,
	output logic [1:0] done_code,
	output logic [5:0] received_count,
	output logic [5:0] available,
	output logic       busy_res
);

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);

	typedef enum logic [1:0] {
		MODE_READY,
		MODE_RX,
		MODE_TX
	} mode_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] addr_byte;
		logic       send_sel;
		logic       pop_hit;
		logic       acc;
		logic       done;
		logic [1:0] code;
		logic [5:0] rcount;
		logic [5:0] avail;
		logic       busy;
	} res_t;

	// Transaction state.
	mode_t         mode_q, mode_d;
	logic [1:0]    fault_q, fault_d;
	logic [7:0]    adir_q, adir_d;
	logic [CW-1:0] tidx_q, tidx_d;
	logic [CW-1:0] tlim_q, tlim_d;
	logic [CW-1:0] scnt_q, scnt_d;
	logic [CW-1:0] ridx_q, ridx_d;
	logic [CW-1:0] rcnt_q, rcnt_d;
	logic [6:0]    ptgt_q, ptgt_d;
	logic [CW-1:0] rqcnt_q, rqcnt_d;

	// Buffers and their registered read data.
	logic [7:0] send_mem [BUFFER_DEPTH];
	logic [7:0] recv_mem [BUFFER_DEPTH];
	logic [7:0] send_rd_q;
	logic [7:0] recv_rd_q;

	logic          out_valid_q;
	res_t          res_q, res_d;
	logic          load;
	logic          exec;
	logic          busy;
	logic          swe;
	logic          rwe;
	logic          fin;
	logic [2:0]    fin_cmd;
	logic [CW-1:0] fin_n;

	// The output register takes a new word whenever it is empty or being taken.
	assign load = !out_valid_q || !out_stall;
	assign exec = load && head_valid;
	assign pop  = exec;
	assign busy = (mode_q != MODE_READY);

	// Execute the head item against the current state.
	always_comb begin
		mode_d  = mode_q;
		fault_d = fault_q;
		adir_d  = adir_q;
		tidx_d  = tidx_q;
		tlim_d  = tlim_q;
		scnt_d  = scnt_q;
		ridx_d  = ridx_q;
		rcnt_d  = rcnt_q;
		ptgt_d  = ptgt_q;
		rqcnt_d = rqcnt_q;
		res_d   = '0;
		swe     = 1'b0;
		rwe     = 1'b0;
		fin     = 1'b0;
		fin_cmd = CMD_NONE;
		fin_n   = '0;
		unique case (head.op)
			OP_BEGIN_WR: begin
				if (!busy) begin
					ptgt_d    = head.addr;
					scnt_d    = '0;
					res_d.acc = 1'b1;
				end
			end
			OP_QUEUE: begin
				if (!busy && scnt_q < DepthC) begin
					swe       = 1'b1;
					scnt_d    = scnt_q + 1'b1;
					res_d.acc = 1'b1;
				end
			end
			OP_START_WR: begin
				if (!busy) begin
					adir_d    = {ptgt_q, 1'b0};
					mode_d    = MODE_TX;
					fault_d   = FAULT_NONE;
					tidx_d    = '0;
					tlim_d    = scnt_q;
					scnt_d    = '0;
					res_d.cmd = CMD_START;
					res_d.acc = 1'b1;
				end
			end
			OP_START_RD: begin
				if (!busy) begin
					res_d.acc = 1'b1;
					fault_d   = FAULT_NONE;
					if (head.count == 8'd0) begin
						// An empty read finishes at once without touching the bus.
						rcnt_d     = '0;
						ridx_d     = '0;
						res_d.done = 1'b1;
					end else begin
						adir_d    = {head.addr, 1'b1};
						mode_d    = MODE_RX;
						tidx_d    = '0;
						tlim_d    = CW'(head.count) - 1'b1;
						rqcnt_d   = CW'(head.count);
						res_d.cmd = CMD_START;
					end
				end
			end
			OP_POP: begin
				if (!busy) begin
					res_d.acc = 1'b1;
					if (ridx_q < rcnt_q && ridx_q < DepthC) begin
						res_d.pop_hit = 1'b1;
						ridx_d        = ridx_q + 1'b1;
					end
				end
			end
			OP_EV_ADDR: begin
				if (busy) begin
					res_d.cmd       = CMD_SEND;
					res_d.addr_byte = adir_q;
				end
			end
			OP_EV_TX_ACK: begin
				if (mode_q == MODE_TX) begin
					if (tidx_q < tlim_q && tidx_q < DepthC) begin
						res_d.cmd      = CMD_SEND;
						res_d.send_sel = 1'b1;
						tidx_d         = tidx_q + 1'b1;
					end else begin
						fin     = 1'b1;
						fin_cmd = CMD_STOP;
					end
				end
			end
			OP_EV_ADDR_NACK_W: begin
				if (mode_q == MODE_TX) begin
					fault_d = FAULT_ADDR_NACK;
					fin     = 1'b1;
					fin_cmd = CMD_STOP;
				end
			end
			OP_EV_DATA_NACK: begin
				if (mode_q == MODE_TX) begin
					fault_d = FAULT_DATA_NACK;
					fin     = 1'b1;
					fin_cmd = CMD_STOP;
				end
			end
			OP_EV_ARB_LOST: begin
				if (busy) begin
					fault_d = FAULT_OTHER;
					fin     = 1'b1;
					fin_cmd = CMD_RELEASE;
				end
			end
			OP_EV_RX_ADDR_ACK: begin
				if (mode_q == MODE_RX) begin
					res_d.cmd = (tidx_q < tlim_q) ? CMD_ACK : CMD_NACK;
				end
			end
			OP_EV_RX_DATA_ACK: begin
				if (mode_q == MODE_RX) begin
					// Bytes past the buffer depth are dropped.
					if (tidx_q < DepthC) begin
						rwe    = 1'b1;
						tidx_d = tidx_q + 1'b1;
					end
					res_d.cmd = (tidx_d < tlim_q) ? CMD_ACK : CMD_NACK;
				end
			end
			OP_EV_RX_DATA_NACK: begin
				if (mode_q == MODE_RX) begin
					if (tidx_q < DepthC) begin
						rwe    = 1'b1;
						tidx_d = tidx_q + 1'b1;
					end
					fin     = 1'b1;
					fin_cmd = CMD_STOP;
				end
			end
			OP_EV_ADDR_NACK_R: begin
				if (mode_q == MODE_RX) begin
					fault_d = FAULT_ADDR_NACK;
					fin     = 1'b1;
					fin_cmd = CMD_STOP;
				end
			end
			OP_EV_BUS_ERR: begin
				if (busy) begin
					fault_d = FAULT_OTHER;
					fin     = 1'b1;
					fin_cmd = CMD_STOP;
				end
			end
			default: begin
			end
		endcase

		// Transaction end: report the code and, for a read, the bytes received.
		if (fin) begin
			res_d.cmd  = fin_cmd;
			res_d.done = 1'b1;
			res_d.code = fault_d;
			if (mode_q == MODE_RX) begin
				fin_n        = (tidx_d < rqcnt_q) ? tidx_d : rqcnt_q;
				rcnt_d       = fin_n;
				ridx_d       = '0;
				res_d.rcount = 6'(fin_n);
			end
			mode_d = MODE_READY;
		end

		res_d.avail = 6'((rcnt_d >= ridx_d) ? (rcnt_d - ridx_d) : '0);
		res_d.busy  = (mode_d != MODE_READY);
	end

	// Send buffer: written by queue byte, read while sending data.
	always_ff @(posedge clk) begin
		if (exec && swe) begin
			send_mem[scnt_q[AW-1:0]] <= head.data;
		end
		if (exec && res_d.send_sel) begin
			send_rd_q <= send_mem[tidx_q[AW-1:0]];
		end
	end

	// Receive buffer: written by bus data events, read by host pops.
	always_ff @(posedge clk) begin
		if (exec && rwe) begin
			recv_mem[tidx_q[AW-1:0]] <= head.data;
		end
		if (exec && res_d.pop_hit) begin
			recv_rd_q <= recv_mem[ridx_q[AW-1:0]];
		end
	end

	// State and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_READY;
			fault_q     <= FAULT_NONE;
			adir_q      <= '0;
			tidx_q      <= '0;
			tlim_q      <= '0;
			scnt_q      <= '0;
			ridx_q      <= '0;
			rcnt_q      <= '0;
			ptgt_q      <= '0;
			rqcnt_q     <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (exec) begin
				mode_q  <= mode_d;
				fault_q <= fault_d;
				adir_q  <= adir_d;
				tidx_q  <= tidx_d;
				tlim_q  <= tlim_d;
				scnt_q  <= scnt_d;
				ridx_q  <= ridx_d;
				rcnt_q  <= rcnt_d;
				ptgt_q  <= ptgt_d;
				rqcnt_q <= rqcnt_d;
			end
			if (load) begin
				out_valid_q <= head_valid;
				res_q       <= res_d;
			end
		end
	end

	// Result word.
	assign out_valid      = out_valid_q;
	assign bus_command    = res_q.cmd;
	assign bus_byte       = res_q.send_sel ? send_rd_q : res_q.addr_byte;
	assign host_byte      = res_q.pop_hit ? recv_rd_q : 8'h00;
	assign accepted       = res_q.acc;
	assign done_res       = res_q.done;
	assign done_code      = res_q.code;
	assign received_count = res_q.rcount;
	assign available      = res_q.avail;
	assign busy_res       = res_q.busy;

endmodule

/* src/i2c_master_transaction_controller.sv */
// I2C master transaction controller: host commands and engine status in,
// engine commands and host status out, one result word for every input word.
//
// Input channel (in_valid / in_stall): each word carries a host action (begin
// write, queue byte, start write, start read, pop byte) or a bus event with the
// engine status. Output channel (out_valid / out_stall): one result word per
// input word, in order, with the engine command, the byte to send, the popped
// byte, acceptance, completion code and buffer fill.
// A word is classified as it is accepted and registered into a two-entry
// queue; from the queue head it is executed into the output register.
// Throughput is one word per cycle while out_stall is low; state updates and
// buffer accesses for one word all happen when the back end executes it.
// When out_stall is high the output word holds; the queue absorbs two more
// words and in_stall then rises until the output is taken.
// Reset clears the transaction state and both channels; the send and receive
// buffers are not cleared and are only read at entries already written.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
module i2c_master_transaction_controller
	import i2cm_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [6:0] target_address,
	input  logic [7:0] data_byte,
	input  logic [7:0] byte_count,
	input  logic [7:0] bus_status,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bus_command,
	output logic [7:0] bus_byte,
	output logic [7:0] host_byte,
	output logic       accepted,
	output logic       done_res,
	output logic [1:0] done_code,
	output logic [5:0] received_count,
	output logic [5:0] available,
	output logic       busy_res
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head;

	// Classify incoming words.
	i2cm_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.target_address(target_address),
		.data_byte     (data_byte),
		.byte_count    (byte_count),
		.bus_status    (bus_status),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	// Decouple front and back.
	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// Execute and deliver results.
	i2cm_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bus_command   (bus_command),
		.bus_byte      (bus_byte),
		.host_byte     (host_byte),
		.accepted      (accepted),
		.done_res      (done_res),
		.done_code     (done_code),
		.received_count(received_count),
		.available     (available),
		.busy_res      (busy_res)
	);

endmodule

/* src/i2cm_checker.sv */
// Port-level checks for the I2C master transaction controller, bound to the top level.
// Depends on i2cm_pkg.
module i2cm_checker
	import i2cm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] bus_command,
	input logic [7:0] host_byte,
	input logic       accepted,
	input logic       done_res,
	input logic [1:0] done_code,
	input logic       busy_res
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bus_command) && $stable(host_byte))
		else $error("stalled result word changed");

	// A finished transaction leaves the block idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("transaction done but still busy");

	// A start is only issued for an accepted host command that opens a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_command == CMD_START |-> accepted && busy_res)
		else $error("start issued without an accepted transaction");

	// A popped byte only comes with an accepted pop.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && host_byte != 8'h00 |-> accepted && !busy_res)
		else $error("host byte returned without an accepted command");

	// A completion code is only reported with a finished transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_code != FAULT_NONE |-> done_res)
		else $error("completion code without done");

endmodule

bind i2c_master_transaction_controller i2cm_checker u_i2cm_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the I2C master transaction controller: directed
// and random host commands and bus events, with expected responses worked
// out in the bench. Depends on i2cm_pkg and the controller's RTL.
module tb;
	import i2cm_pkg::*;

	localparam int DEPTH = 32;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_RX,
		MODE_TX
	} xfer_mode_t;

	typedef struct packed {
		logic [2:0] act;
		logic [6:0] addr;
		logic [7:0] data;
		logic [7:0] count;
		logic [7:0] status;
	} host_word_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] send_byte;
		logic [7:0] popped;
		logic       taken;
		logic       finished;
		logic [1:0] code;
		logic [5:0] rx_total;
		logic [5:0] unread;
		logic       busy;
	} response_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] action;
	logic [6:0] target_address;
	logic [7:0] data_byte;
	logic [7:0] byte_count;
	logic [7:0] bus_status;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] bus_command;
	logic [7:0] bus_byte;
	logic [7:0] host_byte;
	logic       accepted;
	logic       done_res;
	logic [1:0] done_code;
	logic [5:0] received_count;
	logic [5:0] available;
	logic       busy_res;

	i2c_master_transaction_controller #(.BUFFER_DEPTH(DEPTH)) dut (.*);

	// Bench copy of the controller state, starting from its reset values.
	xfer_mode_t mode = MODE_IDLE;
	logic [1:0] fault = FAULT_NONE;
	logic [7:0] addr_dir = '0;
	int         xfer_idx = 0;
	int         xfer_lim = 0;
	logic [7:0] tx_buf [DEPTH];
	int         tx_cnt = 0;
	logic [7:0] rx_buf [DEPTH];
	int         rx_rd = 0;
	int         rx_cnt = 0;
	logic [6:0] pend_tgt = '0;
	int         req_cnt = 0;

	response_t awaited [$];
	int send_gap_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int responses_checked = 0;
	int transfers_done = 0;
	int transfers_failed = 0;
	int mismatches = 0;

	// Ends the running transfer and reports its outcome.
	function automatic void end_transfer(input logic [2:0] cmd, inout response_t r);
		int n;
		r.command = cmd;
		r.finished = 1'b1;
		r.code = fault;
		if (mode == MODE_RX) begin
			n = (xfer_idx < req_cnt) ? xfer_idx : req_cnt;
			rx_cnt = n;
			rx_rd = 0;
			r.rx_total = 6'(n);
		end
		mode = MODE_IDLE;
	endfunction

	// Bytes past the buffer depth are dropped.
	function automatic void capture_byte(input logic [7:0] b);
		if (xfer_idx < DEPTH) begin
			rx_buf[xfer_idx] = b;
			xfer_idx++;
		end
	endfunction

	// Works out the response word for one input word and updates the state.
	function automatic response_t controller_response(input host_word_t w);
		response_t r;
		logic [7:0] st;
		int cnt;
		logic busy;
		r = '0;
		st = w.status & 8'hF8;
		busy = (mode != MODE_IDLE);
		case (w.act)
		ACT_BEGIN_WR: begin
			if (!busy) begin
				pend_tgt = w.addr;
				tx_cnt = 0;
				r.taken = 1'b1;
			end
		end
		ACT_QUEUE: begin
			if (!busy && tx_cnt < DEPTH) begin
				tx_buf[tx_cnt] = w.data;
				tx_cnt++;
				r.taken = 1'b1;
			end
		end
		ACT_START_WR: begin
			if (!busy) begin
				addr_dir = {pend_tgt, 1'b0};
				mode = MODE_TX;
				fault = FAULT_NONE;
				xfer_idx = 0;
				xfer_lim = tx_cnt;
				tx_cnt = 0;
				r.command = CMD_START;
				r.taken = 1'b1;
			end
		end
		ACT_START_RD: begin
			if (!busy) begin
				cnt = (int'(w.count) > DEPTH) ? DEPTH : int'(w.count);
				r.taken = 1'b1;
				fault = FAULT_NONE;
				if (cnt == 0) begin
					// An empty read finishes at once without touching the bus.
					rx_cnt = 0;
					rx_rd = 0;
					r.finished = 1'b1;
				end else begin
					addr_dir = {w.addr, 1'b1};
					mode = MODE_RX;
					xfer_idx = 0;
					xfer_lim = cnt - 1;
					req_cnt = cnt;
					r.command = CMD_START;
				end
			end
		end
		ACT_BUS_EVT: begin
			if (busy) begin
				case (st) inside
				ST_START, ST_RESTART: begin
					r.command = CMD_SEND;
					r.send_byte = addr_dir;
				end
				ST_SLA_W_ACK, ST_DATA_W_ACK: begin
					if (mode == MODE_TX) begin
						if (xfer_idx < xfer_lim && xfer_idx < DEPTH) begin
							r.command = CMD_SEND;
							r.send_byte = tx_buf[xfer_idx];
							xfer_idx++;
						end else begin
							end_transfer(CMD_STOP, r);
						end
					end
				end
				ST_SLA_W_NACK: begin
					if (mode == MODE_TX) begin
						fault = FAULT_ADDR_NACK;
						end_transfer(CMD_STOP, r);
					end
				end
				ST_DATA_W_NACK: begin
					if (mode == MODE_TX) begin
						fault = FAULT_DATA_NACK;
						end_transfer(CMD_STOP, r);
					end
				end
				ST_ARB_LOST: begin
					fault = FAULT_OTHER;
					end_transfer(CMD_RELEASE, r);
				end
				ST_SLA_R_ACK, ST_DATA_R_ACK: begin
					if (mode == MODE_RX) begin
						if (st == ST_DATA_R_ACK)
							capture_byte(w.data);
						r.command = (xfer_idx < xfer_lim) ? CMD_ACK : CMD_NACK;
					end
				end
				ST_DATA_R_NACK: begin
					if (mode == MODE_RX) begin
						capture_byte(w.data);
						end_transfer(CMD_STOP, r);
					end
				end
				ST_SLA_R_NACK: begin
					if (mode == MODE_RX) begin
						fault = FAULT_ADDR_NACK;
						end_transfer(CMD_STOP, r);
					end
				end
				ST_BUS_ERROR: begin
					fault = FAULT_OTHER;
					end_transfer(CMD_STOP, r);
				end
				default: ;
				endcase
			end
		end
		ACT_POP: begin
			if (!busy) begin
				r.taken = 1'b1;
				if (rx_rd < rx_cnt && rx_rd < DEPTH) begin
					r.popped = rx_buf[rx_rd];
					rx_rd++;
				end
			end
		end
		default: ;
		endcase
		r.unread = 6'((rx_cnt >= rx_rd) ? rx_cnt - rx_rd : 0);
		r.busy = (mode != MODE_IDLE);
		return r;
	endfunction

	// Clock and the receiver's random stalls.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Each response word taken is compared with the oldest expectation.
	always @(posedge clk) begin
		response_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				$error("response word with no input word awaiting it");
				mismatches++;
			end else begin
				e = awaited.pop_front();
				responses_checked++;
				if (e.finished) begin
					transfers_done++;
					if (e.code != FAULT_NONE)
						transfers_failed++;
				end
				check_field("bus_command", e.command, bus_command);
				check_field("bus_byte", e.send_byte, bus_byte);
				check_field("host_byte", e.popped, host_byte);
				check_field("accepted", e.taken, accepted);
				check_field("done_res", e.finished, done_res);
				check_field("done_code", e.code, done_code);
				check_field("received_count", e.rx_total, received_count);
				check_field("available", e.unread, available);
				check_field("busy_res", e.busy, busy_res);
			end
		end
	end

	// Sends one word, starting and ending at a falling edge.
	task automatic send_word(input logic [2:0] act, input logic [6:0] addr,
		input logic [7:0] data, input logic [7:0] count, input logic [7:0] status);
		host_word_t w;
		w = '{act: act, addr: addr, data: data, count: count, status: status};
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		target_address <= addr;
		data_byte <= data;
		byte_count <= count;
		bus_status <= status;
		do
			@(posedge clk);
		while (in_stall);
		awaited.push_back(controller_response(w));
		words_sent++;
		@(negedge clk);
	endtask

	// Bus event with random don't-care bits in the unused fields and status.
	task automatic send_event(input logic [7:0] code, input logic [7:0] b);
		send_word(ACT_BUS_EVT, 7'($urandom), b, 8'($urandom), code | 8'($urandom_range(7)));
	endtask

	task automatic send_noise();
		send_word(3'($urandom_range(7)), 7'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	// Drops valid, then waits on falling edges, checking after each, until no response word is awaited.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (awaited.size() != 0);
	endtask

	// Unknown actions, an idle event, refused commands and masked or foreign
	// status codes around one complete two-byte write.
	task automatic test_write_directed();
		send_word(3'd6, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
		send_word(3'd7, 7'h00, 8'h00, 8'h00, 8'h00);
		send_event(ST_START, 8'h00);
		send_word(ACT_BEGIN_WR, 7'h7F, 8'h00, 8'h00, 8'h00);
		send_word(ACT_QUEUE, 7'h00, 8'hFF, 8'h00, 8'h00);
		send_word(ACT_QUEUE, 7'h7F, 8'h00, 8'hFF, 8'hFF);
		send_word(ACT_START_WR, 7'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_QUEUE, 7'h00, 8'h5A, 8'h00, 8'h00);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_START | 8'h07);
		send_word(ACT_BUS_EVT, 7'h00, 8'hA5, 8'h00, ST_DATA_R_ACK);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, 8'h60);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_SLA_W_ACK);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_DATA_W_ACK);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_DATA_W_ACK);
	endtask

	// Empty read, oversized read cut short by lost arbitration, then pops
	// down to an empty buffer.
	task automatic test_read_directed();
		send_word(ACT_START_RD, 7'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_START_RD, 7'h55, 8'h00, 8'hFF, 8'h00);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_START);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_DATA_W_ACK);
		send_word(ACT_POP, 7'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_SLA_R_ACK);
		send_word(ACT_BUS_EVT, 7'h00, 8'hFF, 8'h00, ST_DATA_R_ACK);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_DATA_R_ACK);
		send_word(ACT_BUS_EVT, 7'h00, 8'h00, 8'h00, ST_ARB_LOST);
		send_word(ACT_POP, 7'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_POP, 7'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_POP, 7'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// One write transfer with random length and a random way of ending.
	task automatic run_write_transfer();
		int n_bytes;
		int ending;
		int stop_at;
		n_bytes = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
		ending = $urandom_range(9);
		stop_at = $urandom_range(0, (n_bytes < DEPTH) ? n_bytes : DEPTH);
		send_word(ACT_BEGIN_WR, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		for (int i = 0; i < n_bytes; i++)
			send_word(ACT_QUEUE, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_word(ACT_START_WR, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_event($urandom_range(3) == 0 ? ST_RESTART : ST_START, 8'($urandom));
		if (ending == 0) begin
			send_event(ST_SLA_W_NACK, 8'($urandom));
			return;
		end
		// Step zero answers the address; each later step answers a data byte.
		for (int k = 0; k <= ((n_bytes < DEPTH) ? n_bytes : DEPTH); k++) begin
			if ($urandom_range(19) == 0)
				send_noise();
			if (ending <= 3 && k == stop_at) begin
				case (ending)
				1: send_event(ST_DATA_W_NACK, 8'($urandom));
				2: send_event(ST_ARB_LOST, 8'($urandom));
				default: send_event(ST_BUS_ERROR, 8'($urandom));
				endcase
				return;
			end
			send_event(k == 0 ? ST_SLA_W_ACK : ST_DATA_W_ACK, 8'($urandom));
		end
	endtask

	// One read transfer followed by a few pops, sometimes past the end.
	task automatic run_read_transfer();
		int cnt;
		int eff;
		int n_data;
		int ending;
		int stop_at;
		case ($urandom_range(9))
		0: cnt = 0;
		1: cnt = $urandom_range(30, 255);
		default: cnt = $urandom_range(1, 6);
		endcase
		eff = (cnt < DEPTH) ? cnt : DEPTH;
		n_data = ($urandom_range(7) == 0) ? eff + $urandom_range(1, 4) : eff;
		ending = $urandom_range(9);
		stop_at = $urandom_range(0, n_data - 1);
		send_word(ACT_START_RD, 7'($urandom), 8'($urandom), 8'(cnt), 8'($urandom));
		if (cnt != 0) begin
			send_event($urandom_range(3) == 0 ? ST_RESTART : ST_START, 8'($urandom));
			if (ending == 0) begin
				send_event(ST_SLA_R_NACK, 8'($urandom));
			end else begin
				send_event(ST_SLA_R_ACK, 8'($urandom));
				for (int k = 0; k < n_data; k++) begin
					if ($urandom_range(19) == 0)
						send_noise();
					if (ending <= 2 && k == stop_at) begin
						send_event(ending == 1 ? ST_ARB_LOST : ST_BUS_ERROR, 8'($urandom));
						break;
					end
					send_event(k == n_data - 1 ? ST_DATA_R_NACK : ST_DATA_R_ACK,
						8'($urandom));
				end
			end
		end
		repeat ($urandom_range(0, eff + 2))
			send_word(ACT_POP, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Mostly complete transfers with random content, the rest loose words.
	task automatic test_random_traffic(input int gap_pct, input int stl_pct,
		input int n_words);
		int target;
		send_gap_pct = gap_pct;
		stall_pct = stl_pct;
		target = words_sent + n_words;
		while (words_sent < target) begin
			case ($urandom_range(99)) inside
			[0:39]: run_write_transfer();
			[40:74]: run_read_transfer();
			default: send_noise();
			endcase
			if ($urandom_range(49) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_BEGIN_WR;
		target_address = '0;
		data_byte = '0;
		byte_count = '0;
		bus_status = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tx_buf[i] = '0;
			rx_buf[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_gap_pct = 24;
		stall_pct = 58;
		test_write_directed();
		test_read_directed();
		wait_for_results();
		test_random_traffic(24, 58, 580);
		test_random_traffic(58, 24, 580);
		test_random_traffic(0, 0, 580);

		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d input words and checked %0d response words.",
			words_sent, responses_checked);
		$display("%0d transfers finished, %0d of them with an error code.",
			transfers_done, transfers_failed);
		if (mismatches == 0 && awaited.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop if the handshakes hang.
	initial begin
		#200000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
